// File: src/rtn_pkg.sv
// Shared types and constants for the RTTTL ringtone text-to-notes block.
// Holds the request, response and note-job structs plus the note frequency table.
// No dependencies.
`default_nettype none

package rtn_pkg;

   // One character of ringtone text.
   typedef struct packed {
      logic [7:0] ch;
      logic       first;
   } req_type;

   // One finished note.
   typedef struct packed {
      logic [13:0] freq_hz;
      logic [21:0] duration_us;
      logic        tune_end;
   } rsp_type;

   // Letter index of a pause or of a letter outside a to g.
   localparam logic [2:0] LETTER_NONE = 3'd7;

   // A closed note, handed from the parser to the arithmetic back end.
   typedef struct packed {
      logic [2:0] letter;
      logic       sharp;
      logic [3:0] octave;
      logic [7:0] length;
      logic       dotted;
      logic       tune_end;
   } job_type;

   // Note duration numerator in microseconds and its width.
   localparam int          DIV_BITS = 21;
   localparam logic [20:0] DIVIDEND = 21'd2000000;

   // Base frequency of a letter in octave five. The sharp values are the base values
   // scaled by 1.0595 and truncated.
   function automatic logic [9:0] note_base(input logic [2:0] letter, input logic sharp);
      logic [9:0] f;
      case (letter)
         3'd0:    f = sharp ? 10'd466 : 10'd440;
         3'd1:    f = sharp ? 10'd523 : 10'd494;
         3'd2:    f = sharp ? 10'd554 : 10'd523;
         3'd3:    f = sharp ? 10'd621 : 10'd587;
         3'd4:    f = sharp ? 10'd698 : 10'd659;
         3'd5:    f = sharp ? 10'd739 : 10'd698;
         3'd6:    f = sharp ? 10'd830 : 10'd784;
         default: f = 10'd0;
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

// File: src/rtn_fifo.sv
// Small register-based queue used between the parser, the back end and the output.
// Depends on nothing but its parameters.
`default_nettype none

module rtn_fifo #(
   parameter int  DEPTH = 2,
   parameter type T     = logic
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  T     wdata,
   output logic full,
   input  logic pop,
   output T     rdata,
   output logic empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   T                 mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a write");
`endif

endmodule

`default_nettype wire

// File: src/rtn_front.sv
// Character parser: walks the ringtone text and emits one note job per closed note.
// Depends on rtn_pkg for the request and job types.
`default_nettype none

module rtn_front
   import rtn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type item,
   output logic    job_push,
   output job_type job
);

   typedef enum logic [11:0] {
      PH_TITLE  = 12'b0000_0000_0001,
      PH_DEFS   = 12'b0000_0000_0010,
      PH_DEFVAL = 12'b0000_0000_0100,
      PH_START  = 12'b0000_0000_1000,
      PH_DUR1   = 12'b0000_0001_0000,
      PH_DUR2   = 12'b0000_0010_0000,
      PH_LETTER = 12'b0000_0100_0000,
      PH_SHARP  = 12'b0000_1000_0000,
      PH_DOT    = 12'b0001_0000_0000,
      PH_OCT    = 12'b0010_0000_0000,
      PH_CLOSE  = 12'b0100_0000_0000,
      PH_DONE   = 12'b1000_0000_0000
   } phase_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_G     = 8'h67;
   localparam logic [7:0] CH_O     = 8'h6F;

   localparam logic [1:0] SET_OTHER = 2'd0;
   localparam logic [1:0] SET_D     = 2'd1;
   localparam logic [1:0] SET_O     = 2'd2;
   localparam logic [1:0] SET_B     = 2'd3;

   phase_type  phase_ff, phase_in, phase_cur;
   logic [7:0] def_len_ff, def_len_in, def_len_cur;
   logic [3:0] def_oct_ff, def_oct_in, def_oct_cur;
   logic [1:0] set_let_ff, set_let_in, set_let_cur;
   logic [7:0] set_val_ff, set_val_in, set_val_cur;
   logic [7:0] len_ff, len_in, len_cur;
   logic [3:0] oct_ff, oct_in, oct_cur;
   logic [2:0] letter_ff, letter_in, letter_cur;
   logic       sharp_ff, sharp_in, sharp_cur;
   logic       dot_ff, dot_in, dot_cur;

   logic [7:0] c;
   logic       is_dig, is_low;
   logic       st_dur1, st_dur2, st_letter, st_sharp, st_dot, st_oct, st_close;
   logic       close;

   // Decimal accumulate with saturation at 255.
   function automatic logic [7:0] sat_acc(input logic [7:0] v, input logic [7:0] ch);
      logic [11:0] r;
      r = {4'b0, v} * 12'd10 + {8'b0, 4'(ch - CH_ZERO)};
      return (r > 12'd255) ? 8'd255 : r[7:0];
   endfunction

   assign c      = item.ch;
   assign is_dig = (c >= CH_ZERO) && (c <= 8'h39);
   assign is_low = (c >= CH_A) && (c <= 8'h7A);

   always_comb begin
      // A first character restarts the tune from the reset state.
      if (item.first) begin
         phase_cur   = PH_TITLE;
         def_len_cur = 8'd4;
         def_oct_cur = 4'd6;
         set_let_cur = SET_OTHER;
         set_val_cur = '0;
         len_cur     = '0;
         oct_cur     = '0;
         letter_cur  = LETTER_NONE;
         sharp_cur   = 1'b0;
         dot_cur     = 1'b0;
      end else begin
         phase_cur   = phase_ff;
         def_len_cur = def_len_ff;
         def_oct_cur = def_oct_ff;
         set_let_cur = set_let_ff;
         set_val_cur = set_val_ff;
         len_cur     = len_ff;
         oct_cur     = oct_ff;
         letter_cur  = letter_ff;
         sharp_cur   = sharp_ff;
         dot_cur     = dot_ff;
      end

      phase_in   = phase_cur;
      def_len_in = def_len_cur;
      def_oct_in = def_oct_cur;
      set_let_in = set_let_cur;
      set_val_in = set_val_cur;
      len_in     = len_cur;
      oct_in     = oct_cur;
      letter_in  = letter_cur;
      sharp_in   = sharp_cur;
      dot_in     = dot_cur;
      close      = 1'b0;

      // Every note starts from the defaults.
      if (phase_cur == PH_START) begin
         len_in    = def_len_cur;
         oct_in    = def_oct_cur;
         letter_in = LETTER_NONE;
         sharp_in  = 1'b0;
         dot_in    = 1'b0;
      end

      // Optional note fields fall through to the next slot when absent.
      st_dur1   = (phase_cur == PH_START) || (phase_cur == PH_DUR1);
      st_dur2   = st_dur1 || (phase_cur == PH_DUR2);
      st_letter = st_dur2 || (phase_cur == PH_LETTER);
      st_sharp  = (phase_cur == PH_SHARP);
      st_dot    = st_sharp || (phase_cur == PH_DOT);
      st_oct    = st_dot || (phase_cur == PH_OCT);
      st_close  = st_oct || (phase_cur == PH_CLOSE);

      case (phase_cur)
         PH_TITLE: begin
            if (c == CH_NUL) begin
               phase_in = PH_DONE;
            end else if (c == CH_COLON) begin
               phase_in = PH_DEFS;
            end
         end
         PH_DEFS: begin
            if (c == CH_NUL) begin
               phase_in = PH_DONE;
            end else if (c == CH_COLON) begin
               phase_in = PH_START;
            end else if (is_low) begin
               set_let_in = (c == CH_D) ? SET_D :
                            (c == CH_O) ? SET_O :
                            (c == CH_B) ? SET_B : SET_OTHER;
               set_val_in = '0;
               phase_in   = PH_DEFVAL;
            end
         end
         PH_DEFVAL: begin
            if (c == CH_NUL) begin
               phase_in = PH_DONE;
            end else if (is_dig) begin
               set_val_in = sat_acc(set_val_cur, c);
            end else if ((c == CH_COLON) || (c == CH_COMMA)) begin
               if (set_let_cur == SET_D) begin
                  def_len_in = set_val_cur;
               end else if (set_let_cur == SET_O) begin
                  def_oct_in = (set_val_cur > 8'd9) ? 4'd9 : set_val_cur[3:0];
               end
               phase_in = (c == CH_COLON) ? PH_START : PH_DEFS;
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            if (st_dur1 && (c == CH_NUL)) begin
               phase_in = PH_DONE;
            end else if (st_dur1 && is_dig) begin
               len_in   = {4'b0, 4'(c - CH_ZERO)};
               phase_in = PH_DUR2;
            end else if (st_dur2 && is_dig) begin
               len_in   = sat_acc(len_cur, c);
               phase_in = PH_LETTER;
            end else if (st_letter) begin
               if (is_low) begin
                  letter_in = (c <= CH_G) ? 3'(c - CH_A) : LETTER_NONE;
               end
               phase_in = PH_SHARP;
            end else if (st_sharp && (c == CH_HASH)) begin
               sharp_in = 1'b1;
               phase_in = PH_DOT;
            end else if (st_dot && (c == CH_DOT)) begin
               dot_in   = 1'b1;
               phase_in = PH_OCT;
            end else if (st_oct && is_dig) begin
               oct_in   = 4'(c - CH_ZERO);
               phase_in = PH_CLOSE;
            end else if (st_close && ((c == CH_COMMA) || (c == CH_NUL))) begin
               close    = 1'b1;
               phase_in = (c == CH_NUL) ? PH_DONE : PH_START;
            end else begin
               phase_in = PH_CLOSE;
            end
         end
      endcase
   end

   // A note only closes in the sharp slot or later, so the held fields are final.
   assign job_push     = accept && close;
   assign job.letter   = letter_cur;
   assign job.sharp    = sharp_cur;
   assign job.octave   = oct_cur;
   assign job.length   = len_cur;
   assign job.dotted   = dot_cur;
   assign job.tune_end = (c == CH_NUL);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TITLE;
         def_len_ff <= 8'd4;
         def_oct_ff <= 4'd6;
         set_let_ff <= SET_OTHER;
         set_val_ff <= '0;
         len_ff     <= '0;
         oct_ff     <= '0;
         letter_ff  <= LETTER_NONE;
         sharp_ff   <= 1'b0;
         dot_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         def_len_ff <= def_len_in;
         def_oct_ff <= def_oct_in;
         set_let_ff <= set_let_in;
         set_val_ff <= set_val_in;
         len_ff     <= len_in;
         oct_ff     <= oct_in;
         letter_ff  <= letter_in;
         sharp_ff   <= sharp_in;
         dot_ff     <= dot_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_restart_no_note: assert property (@(posedge clock) disable iff (reset)
      (accept && item.first) |-> !job_push)
      else $error("note emitted on the first character of a tune");

   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE && !(accept && item.first)) |=> (phase_ff == PH_DONE))
      else $error("parser left the finished state without a restart");

   a_octave_range: assert property (@(posedge clock) disable iff (reset)
      job_push |-> (job.octave <= 4'd9))
      else $error("note octave out of range");
`endif

endmodule

`default_nettype wire

// File: src/rtn_back.sv
// Note arithmetic: serial duration divide, dotted scaling and octave shift.
// Depends on rtn_pkg for the job and response types and the frequency table.
`default_nettype none

module rtn_back
   import rtn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    job_empty,
   input  job_type job,
   output logic    job_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp
);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_DIV  = 3'b010,
      B_DONE = 3'b100
   } bstate_type;

   localparam int CNT_W = $clog2(DIV_BITS);

   bstate_type          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [7:0]          rem_ff, rem_in;
   logic [DIV_BITS-1:0] quot_ff, quot_in;
   logic [7:0]          divisor_ff, divisor_in;
   job_type             job_ff, job_in;

   logic [8:0]  trial;
   logic        ge;
   logic [8:0]  diff;
   logic [22:0] sum3;
   logic [3:0]  oct_c;
   logic [2:0]  shift;

   // One restoring division step per cycle.
   assign trial = {rem_ff, quot_ff[DIV_BITS-1]};
   assign ge    = (trial >= {1'b0, divisor_ff});
   assign diff  = trial - {1'b0, divisor_ff};

   assign job_pop  = (state_ff == B_IDLE) && !job_empty;
   assign rsp_push = (state_ff == B_DONE) && !rsp_full;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      job_in     = job_ff;
      case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               job_in     = job;
               divisor_in = (job.length == 8'd0) ? 8'd1 : job.length;
               rem_in     = '0;
               quot_in    = DIVIDEND;
               count_in   = CNT_W'(DIV_BITS - 1);
               state_in   = B_DIV;
            end
         end
         B_DIV: begin
            rem_in  = ge ? diff[7:0] : trial[7:0];
            quot_in = {quot_ff[DIV_BITS-2:0], ge};
            if (count_ff == '0) begin
               state_in = B_DONE;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         B_DONE: begin
            if (!rsp_full) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      sum3  = {2'b0, quot_ff} + {1'b0, quot_ff, 1'b0};
      oct_c = (job_ff.octave > 4'd9) ? 4'd9 : job_ff.octave;
      shift = (oct_c > 4'd5) ? 3'(oct_c - 4'd5) : 3'd0;
      rsp.freq_hz     = {4'b0, note_base(job_ff.letter, job_ff.sharp)} << shift;
      rsp.duration_us = job_ff.dotted ? sum3[22:1] : {1'b0, quot_ff};
      rsp.tune_end    = job_ff.tune_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
      job_ff     <= job_in;
   end

`ifndef NO_ASSERTIONS
   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV && count_ff != '0) |=> (state_ff == B_DIV))
      else $error("divide left before its last step");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV || state_ff == B_DONE) |-> (rem_ff < divisor_ff))
      else $error("division remainder not below divisor");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (divisor_ff != 8'd0))
      else $error("division by zero started");
`endif

endmodule

`default_nettype wire

// File: src/ringtone_text_to_notes_top.sv
// Top level of the RTTTL ringtone text-to-notes block.
// Depends on rtn_pkg, rtn_front, rtn_fifo and rtn_back.
//
// The block reads ringtone text one character per beat and writes one beat per note.
// Input side: drive req_data and raise push; a character is taken on each clock edge
// where push is high and full is low. Set req_data.first on the first character of a
// tune to restart the parser from its reset state.
// Result side: while empty is low, rsp_data holds the oldest finished note; raise pop
// to take it. Notes come out in text order with freq_hz, duration_us and tune_end.
// Flow: the parser takes one character every cycle while full is low. Each note then
// passes through the back end as a load step, the bit-serial duration divide and a
// write step; the back end takes its next note only after writing the last one.
// Up to JOB_DEPTH closed notes wait in the job queue; full is high while that queue is
// full. When the receiver stalls, up to RSP_DEPTH results wait in the result queue,
// then the back end holds its note and the job queue fills behind it.
// Reset clears the parser to the title phase with length 4 and octave 6 and empties
// both queues.
`default_nettype none

module ringtone_text_to_notes_top
   import rtn_pkg::*;
#(
   parameter int JOB_DEPTH = 2,
   parameter int RSP_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic    accept;
   logic    job_push;
   job_type job_wdata;
   logic    job_full;
   logic    job_pop;
   job_type job_rdata;
   logic    job_empty;
   logic    rsp_push;
   rsp_type rsp_wdata;
   logic    rsp_full;

   // The parser is held off whenever the job queue has no room, so a closing
   // character can always write its note.
   assign full   = job_full;
   assign accept = push && !job_full;

   // Front end: classifies each character and builds note jobs.
   rtn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .item     (req_data),
      .job_push (job_push),
      .job      (job_wdata)
   );

   // Queue of closed notes between the parser and the arithmetic.
   rtn_fifo #(
      .DEPTH (JOB_DEPTH),
      .T     (job_type)
   ) u_job_q (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .wdata (job_wdata),
      .full  (job_full),
      .pop   (job_pop),
      .rdata (job_rdata),
      .empty (job_empty)
   );

   // Back end: computes frequency and duration for one note at a time.
   rtn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (job_rdata),
      .job_pop   (job_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_wdata)
   );

   // Result queue that decouples the back end from the receiver.
   rtn_fifo #(
      .DEPTH (RSP_DEPTH),
      .T     (rsp_type)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wdata),
      .full  (rsp_full),
      .pop   (pop && !empty),
      .rdata (rsp_data),
      .empty (empty)
   );

endmodule

`default_nettype wire
